FILE: src/jslu_pkg.sv
// ----------------------------------------------------------------------------
// jslu_pkg
// Shared types, character constants and small decode functions for the
// string literal unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jslu_pkg;

   // Character codes
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_QMARK     = 8'h3f;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;

   // Hex escape lengths and the limit below which a value is passed through as-is
   localparam logic [2:0]  HEX_DIGITS_X = 3'd2;
   localparam logic [2:0]  HEX_DIGITS_U = 3'd4;
   localparam logic [15:0] HEX_LIMIT    = 16'd128;

   // One result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      logic       fail;
   } rsp_type;

   // Character after a backslash -> produced byte (x and u handled elsewhere)
   function automatic logic [7:0] esc_map(input logic [7:0] c);
      logic [7:0] v;
      begin
         case (c)
            8'h6e:   v = 8'h0a;   // n
            8'h72:   v = 8'h0d;   // r
            8'h74:   v = 8'h09;   // t
            8'h76:   v = 8'h0b;   // v
            8'h62:   v = 8'h08;   // b
            8'h66:   v = 8'h0c;   // f
            8'h30:   v = 8'h00;   // 0
            default: v = c;
         endcase
         return v;
      end
   endfunction

   // Hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      logic [7:0] t;
      begin
         r = '0;
         t = '0;
         if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            r = {1'b1, t[3:0]};
         end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            r = {1'b1, t[3:0]};
         end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            r = {1'b1, t[3:0]};
         end
         return r;
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/jslu_core.sv
// ----------------------------------------------------------------------------
// jslu_core
// Literal parser state and the single-pass step logic: from the registered
// input byte and the current state it forms the next state and at most one
// result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jslu_core
   import jslu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] in_byte,
   input  wire logic       is_last,
   input  wire logic       advance,   // commit the step for the held byte
   output rsp_type         step_rsp,
   output logic            step_emit
);

   localparam logic [1:0] PH_OPEN = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_ESC  = 2'd2;
   localparam logic [1:0] PH_HEX  = 2'd3;

   logic [1:0]  phase_ff,  phase_in;
   logic        single_ff, single_in;
   logic [2:0]  digits_ff, digits_in;
   logic [15:0] hex_ff,    hex_in;
   logic        error_ff,  error_in;

   logic [7:0]  quote_char;
   logic [4:0]  nib;
   logic [15:0] hex_next;
   logic [2:0]  digits_dec;

   assign quote_char = single_ff ? CH_SQUOTE : CH_DQUOTE;
   assign nib        = hex_nibble(in_byte);
   assign hex_next   = {hex_ff[11:0], nib[3:0]};
   assign digits_dec = (digits_ff != 3'd0) ? digits_ff - 3'd1 : 3'd0;

   // Step logic
   always_comb begin
      phase_in  = phase_ff;
      single_in = single_ff;
      digits_in = digits_ff;
      hex_in    = hex_ff;
      error_in  = error_ff;
      step_rsp  = '0;
      step_emit = 1'b0;

      if (phase_ff == PH_OPEN) begin
         // opening quote
         if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
            single_in = (in_byte == CH_SQUOTE);
         end else begin
            error_in = 1'b1;
         end
         if (is_last) begin
            step_emit         = 1'b1;
            step_rsp.done_res = 1'b1;
            step_rsp.fail     = 1'b1;
         end else begin
            phase_in = PH_BODY;
         end
      end else if (error_ff) begin
         // swallow bytes until the end of a bad literal
         if (is_last) begin
            step_emit         = 1'b1;
            step_rsp.done_res = 1'b1;
            step_rsp.fail     = 1'b1;
         end
      end else if (is_last) begin
         // closing byte
         step_emit         = 1'b1;
         step_rsp.done_res = 1'b1;
         if (phase_ff == PH_BODY) begin
            step_rsp.fail = (in_byte != quote_char);
         end else if (phase_ff == PH_ESC && in_byte == quote_char) begin
            step_rsp.out_byte   = quote_char;
            step_rsp.byte_valid = 1'b1;
         end else begin
            step_rsp.fail = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_BODY: begin
               if (in_byte == CH_BACKSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  step_emit           = 1'b1;
                  step_rsp.out_byte   = in_byte;
                  step_rsp.byte_valid = 1'b1;
               end
            end
            PH_ESC: begin
               if (in_byte == CH_LOWER_X || in_byte == CH_LOWER_U) begin
                  phase_in  = PH_HEX;
                  digits_in = (in_byte == CH_LOWER_X) ? HEX_DIGITS_X : HEX_DIGITS_U;
                  hex_in    = '0;
               end else begin
                  phase_in            = PH_BODY;
                  step_emit           = 1'b1;
                  step_rsp.out_byte   = esc_map(in_byte);
                  step_rsp.byte_valid = 1'b1;
               end
            end
            PH_HEX: begin
               if (!nib[4]) begin
                  error_in = 1'b1;
               end else if (digits_dec == 3'd0) begin
                  phase_in            = PH_BODY;
                  digits_in           = 3'd0;
                  hex_in              = '0;
                  step_emit           = 1'b1;
                  step_rsp.out_byte   = (hex_next < HEX_LIMIT) ? hex_next[7:0] : CH_QMARK;
                  step_rsp.byte_valid = 1'b1;
               end else begin
                  digits_in = digits_dec;
                  hex_in    = hex_next;
               end
            end
            default: begin
               phase_in = PH_OPEN;
            end
         endcase
      end

      // end of literal: back to the idle state
      if (is_last) begin
         phase_in  = PH_OPEN;
         single_in = 1'b0;
         digits_in = 3'd0;
         hex_in    = '0;
         error_in  = 1'b0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPEN;
         single_ff <= 1'b0;
         digits_ff <= 3'd0;
         hex_ff    <= '0;
         error_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         single_ff <= single_in;
         digits_ff <= digits_in;
         hex_ff    <= hex_in;
         error_ff  <= error_in;
      end
   end

   // Checks
   a_hex_has_digits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEX && !error_ff) |-> (digits_ff != 3'd0))
      else $error("hex phase with no digits pending");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && is_last) |=> (phase_ff == PH_OPEN && !error_ff))
      else $error("state not cleared after last byte");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      is_last |-> (step_emit && step_rsp.done_res))
      else $error("last byte without done beat");

endmodule

`default_nettype wire

FILE: src/jslu_rsp_reg.sv
// ----------------------------------------------------------------------------
// jslu_rsp_reg
// Result register: holds one result beat until the consumer takes it and
// reports whether it can accept a new beat in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jslu_rsp_reg
   import jslu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_rsp,
   output logic         space,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    vld_ff, vld_in;
   rsp_type data_ff;

   assign space  = !vld_ff || rsp_ready;
   assign vld_in = load || (vld_ff && !rsp_ready);

   // Valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_rsp;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

FILE: src/js_string_literal_unescaper.sv
// Path: an accepted byte is held in the input register, and its result beat in the result register.
// Throughput: one byte per cycle; the held byte moves on as soon as the
// result register is free or being emptied in the same cycle.
// Bytes that produce no result never wait for the result register.
// Reset (synchronous, active high) empties both registers and returns the
// parser to expecting an opening quote.
// ----------------------------------------------------------------------------
// js_string_literal_unescaper
// Unescapes a quoted string literal fed one byte per beat; emits one beat per
// produced character and a done beat, with a fail flag, on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module js_string_literal_unescaper
   import jslu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_is_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_done_res,
   output logic            rsp_fail
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   logic       step_emit;
   logic       space;
   rsp_type    step_rsp;
   rsp_type    rsp_data;

   // Input stage handshake
   assign advance   = in_vld_ff && (!step_emit || space);
   assign req_ready = !in_vld_ff || advance;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_is_last;
      end
   end

   // Parser step
   jslu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_byte   (in_byte_ff),
      .is_last   (in_last_ff),
      .advance   (advance),
      .step_rsp  (step_rsp),
      .step_emit (step_emit)
   );

   // Result register
   jslu_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && step_emit),
      .load_rsp  (step_rsp),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte   = rsp_data.out_byte;
   assign rsp_byte_valid = rsp_data.byte_valid;
   assign rsp_done_res   = rsp_data.done_res;
   assign rsp_fail       = rsp_data.fail;

   // Checks
   a_fail_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fail) |-> rsp_done_res)
      else $error("fail without done");

   a_beat_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_valid || rsp_done_res))
      else $error("empty result beat");

   a_fail_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fail) |-> !rsp_byte_valid)
      else $error("failed literal carries a byte");

   a_held_byte_moves: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && (!rsp_valid || rsp_ready)) |-> advance)
      else $error("input stage stalled with free result register");

endmodule

`default_nettype wire

FILE: tb/jslu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jslu_checker
// Watches both channels of the string literal unescaper. Each accepted input
// beat runs through a local model of the parser, which queues the result
// beat it should cause; each accepted result beat is checked field by field
// against the oldest queued beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jslu_checker
   import jslu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_is_last,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_byte_valid,
   input  wire logic       rsp_done_res,
   input  wire logic       rsp_fail,
   output int              mismatch_count,
   output int              pending_count
);

   typedef enum logic [1:0] {
      P_OPEN,
      P_BODY,
      P_ESC,
      P_HEX
   } parse_phase_type;

   // Parser state of the model
   parse_phase_type ph;
   logic         quote_single;
   logic [2:0]   digits_due;
   logic [15:0]  acc;
   logic         bad_seen;

   rsp_type      unescaped_q[$];
   rsp_type      want;
   int           errs = 0;

   task automatic clear_parser();
      ph           = P_OPEN;
      quote_single = 1'b0;
      digits_due   = '0;
      acc          = '0;
      bad_seen     = 1'b0;
   endtask

   task automatic push_result(input logic [7:0] c, input logic vld, input logic done,
                              input logic bad);
      rsp_type r;
      r.out_byte   = vld ? c : 8'h00;
      r.byte_valid = vld;
      r.done_res   = done;
      r.fail       = bad;
      unescaped_q.push_back(r);
   endtask

   // Hex digit value, or -1 for anything else
   function automatic int digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   // One raw byte through the model parser
   task automatic unescape_byte(input logic [7:0] b, input logic last);
      logic [7:0] close_ch;
      int         nib;
      close_ch = quote_single ? CH_SQUOTE : CH_DQUOTE;
      if (ph == P_OPEN) begin
         if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            quote_single = (b == CH_SQUOTE);
         end else begin
            bad_seen = 1'b1;
         end
         if (last) begin
            push_result(8'h00, 1'b0, 1'b1, 1'b1);
            clear_parser();
         end else begin
            ph = P_BODY;
         end
      end else if (bad_seen) begin
         // malformed literal: swallow bytes until the last one
         if (last) begin
            push_result(8'h00, 1'b0, 1'b1, 1'b1);
            clear_parser();
         end
      end else if (last) begin
         if (ph == P_BODY) begin
            push_result(8'h00, 1'b0, 1'b1, b != close_ch);
         end else if (ph == P_ESC && b == close_ch) begin
            // lone backslash: the closing quote comes out as a character
            push_result(close_ch, 1'b1, 1'b1, 1'b0);
         end else begin
            push_result(8'h00, 1'b0, 1'b1, 1'b1);
         end
         clear_parser();
      end else begin
         case (ph)
            P_BODY: begin
               if (b == CH_BACKSLASH) begin
                  ph = P_ESC;
               end else begin
                  push_result(b, 1'b1, 1'b0, 1'b0);
               end
            end
            P_ESC: begin
               ph = P_BODY;
               case (b)
                  "n":     push_result(8'h0a, 1'b1, 1'b0, 1'b0);
                  "r":     push_result(8'h0d, 1'b1, 1'b0, 1'b0);
                  "t":     push_result(8'h09, 1'b1, 1'b0, 1'b0);
                  "v":     push_result(8'h0b, 1'b1, 1'b0, 1'b0);
                  "b":     push_result(8'h08, 1'b1, 1'b0, 1'b0);
                  "f":     push_result(8'h0c, 1'b1, 1'b0, 1'b0);
                  "0":     push_result(8'h00, 1'b1, 1'b0, 1'b0);
                  CH_LOWER_X, CH_LOWER_U: begin
                     ph         = P_HEX;
                     digits_due = (b == CH_LOWER_X) ? HEX_DIGITS_X : HEX_DIGITS_U;
                     acc        = '0;
                  end
                  default: push_result(b, 1'b1, 1'b0, 1'b0);
               endcase
            end
            default: begin
               nib = digit_of(b);
               if (nib < 0) begin
                  bad_seen = 1'b1;
               end else begin
                  acc = {acc[11:0], nib[3:0]};
                  if (digits_due != 0) digits_due = digits_due - 1'b1;
                  if (digits_due == 0) begin
                     // wide values collapse to a question mark
                     push_result((acc < HEX_LIMIT) ? acc[7:0] : CH_QMARK, 1'b1, 1'b0, 1'b0);
                     ph  = P_BODY;
                     acc = '0;
                  end
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         unescaped_q.delete();
      end else begin
         // result side first, so a stray beat never matches this edge's input
         if (rsp_valid && rsp_ready) begin
            if (unescaped_q.size() == 0) begin
               $error("unexpected result beat: out_byte %h byte_valid %b done_res %b fail %b",
                      rsp_out_byte, rsp_byte_valid, rsp_done_res, rsp_fail);
               errs++;
            end else begin
               want = unescaped_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_out_byte);
                  errs++;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %b, actual %b", want.byte_valid,
                         rsp_byte_valid);
                  errs++;
               end
               if (rsp_done_res !== want.done_res) begin
                  $error("done_res: expected %b, actual %b", want.done_res, rsp_done_res);
                  errs++;
               end
               if (rsp_fail !== want.fail) begin
                  $error("fail: expected %b, actual %b", want.fail, rsp_fail);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) unescape_byte(req_in_byte, req_is_last);
      end
      mismatch_count <= errs;
      pending_count  <= unescaped_q.size();
   end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives quoted literals into the string literal unescaper: a few hand-made
// corner literals, then random well-formed, broken and noise literals under
// three idling mixes, one long receiver hold-off and one drain pause. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
   import jslu_pkg::*;
();

   localparam int HOLD_CYCLES  = 200;
   localparam int PHASE_BYTES  = 370;
   localparam int PRESSURE_LEN = 40;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_done_res;
   logic       rsp_fail;
   int         mismatch_count;
   int         pending_count;

   int         send_gap_pct  = 26;
   int         rsp_stall_pct = 71;
   bit         hold_req      = 1'b0;
   logic [7:0] lit_q[$];
   bit         lit_is_noise;
   string      esc_letters   = "nrtvbf0";

   always #6 clock = ~clock;

   js_string_literal_unescaper dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_fail       (rsp_fail)
   );

   jslu_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_fail       (rsp_fail),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   function automatic bit is_xdigit(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   // Hex digit character, random letter case
   function automatic logic [7:0] nibble_glyph(input logic [3:0] n);
      logic [7:0] base;
      base = $urandom_range(1) ? 8'h61 : 8'h41;
      return (n < 4'd10) ? (8'h30 + 8'(n)) : (base + 8'(n) - 8'd10);
   endfunction

   // One well-formed body element: plain byte, short escape, \x or \u escape
   task automatic add_element();
      int         k;
      logic [7:0] c;
      logic [15:0] val;
      k = $urandom_range(9);
      if (k < 5) begin
         do c = 8'($urandom_range(255)); while (c == CH_BACKSLASH);
         lit_q.push_back(c);
      end else if (k < 7) begin
         lit_q.push_back(CH_BACKSLASH);
         if ($urandom_range(1)) begin
            lit_q.push_back(esc_letters[$urandom_range(6)]);
         end else begin
            do c = 8'($urandom_range(255)); while (c == CH_LOWER_X || c == CH_LOWER_U);
            lit_q.push_back(c);
         end
      end else if (k < 8) begin
         val = 16'($urandom_range(255));
         lit_q.push_back(CH_BACKSLASH);
         lit_q.push_back(CH_LOWER_X);
         lit_q.push_back(nibble_glyph(val[7:4]));
         lit_q.push_back(nibble_glyph(val[3:0]));
      end else begin
         val = $urandom_range(1) ? 16'($urandom_range(255)) : 16'($urandom_range(65535));
         lit_q.push_back(CH_BACKSLASH);
         lit_q.push_back(CH_LOWER_U);
         lit_q.push_back(nibble_glyph(val[15:12]));
         lit_q.push_back(nibble_glyph(val[11:8]));
         lit_q.push_back(nibble_glyph(val[7:4]));
         lit_q.push_back(nibble_glyph(val[3:0]));
      end
   endtask

   // Random literal: mostly well formed, some broken, a few pure noise
   task automatic build_literal();
      int         kind;
      int         n;
      int         digits;
      logic [7:0] q;
      logic [7:0] c;
      lit_q.delete();
      lit_is_noise = 1'b0;
      q    = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      kind = $urandom_range(99);
      if (kind >= 88) begin
         lit_is_noise = 1'b1;
         repeat ($urandom_range(8, 1)) lit_q.push_back(8'($urandom_range(255)));
         return;
      end
      lit_q.push_back(q);
      repeat ($urandom_range(8)) add_element();
      if (kind < 70) begin
         if ($urandom_range(6) == 0) lit_q.push_back(CH_BACKSLASH);
         lit_q.push_back(q);
         return;
      end
      case (kind % 6)
         0: begin
            // bad opening byte
            do c = 8'($urandom_range(255)); while (c == CH_SQUOTE || c == CH_DQUOTE);
            lit_q[0] = c;
            lit_q.push_back(q);
         end
         1: begin
            // closing byte does not match
            do c = 8'($urandom_range(255)); while (c == q);
            lit_q.push_back(c);
         end
         2: begin
            // bad hex digit, then more body
            n = $urandom_range(1) ? 2 : 4;
            lit_q.push_back(CH_BACKSLASH);
            lit_q.push_back((n == 2) ? CH_LOWER_X : CH_LOWER_U);
            repeat ($urandom_range(n - 1))
               lit_q.push_back(nibble_glyph(4'($urandom_range(15))));
            do c = 8'($urandom_range(255)); while (is_xdigit(c));
            lit_q.push_back(c);
            repeat ($urandom_range(3)) add_element();
            lit_q.push_back(q);
         end
         3: begin
            // literal ends inside a hex escape
            n      = $urandom_range(1) ? 2 : 4;
            digits = $urandom_range(n - 1);
            lit_q.push_back(CH_BACKSLASH);
            lit_q.push_back((n == 2) ? CH_LOWER_X : CH_LOWER_U);
            repeat (digits) lit_q.push_back(nibble_glyph(4'($urandom_range(15))));
            lit_q.push_back(q);
         end
         4: begin
            // one-byte literal
            lit_q.delete();
            lit_q.push_back(q);
         end
         default: begin
            // ends right after a backslash on a non-closing byte
            do c = 8'($urandom_range(255)); while (c == q);
            lit_q.push_back(CH_BACKSLASH);
            lit_q.push_back(c);
         end
      endcase
   endtask

   // Offer one beat, with a random gap first
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_is_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_lit();
      int i;
      for (i = 0; i < lit_q.size(); i++) send_byte(lit_q[i], i == lit_q.size() - 1);
   endtask

   // Drop valid and wait until every queued result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int counted;
      int p;
      int i;
      logic [7:0] c;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corner literals
      lit_q = '{CH_DQUOTE};
      send_lit();
      lit_q = '{CH_SQUOTE, CH_SQUOTE};
      send_lit();
      lit_q = '{8'hff, 8'h00};
      send_lit();
      lit_q = '{CH_DQUOTE, CH_BACKSLASH, CH_DQUOTE};
      send_lit();
      lit_q = '{CH_SQUOTE, CH_BACKSLASH, CH_LOWER_X, 8'h5a, CH_SQUOTE};
      send_lit();
      lit_q = '{CH_DQUOTE, CH_BACKSLASH, CH_LOWER_U, 8'h37, CH_DQUOTE};
      send_lit();
      lit_q = '{CH_SQUOTE, CH_BACKSLASH, CH_LOWER_U, 8'h46, 8'h46, 8'h66, 8'h46, CH_DQUOTE};
      send_lit();

      // random literals under three idling mixes
      for (p = 0; p < 3; p++) begin
         send_gap_pct  = (p == 0) ? 26 : (p == 1) ? 71 : 0;
         rsp_stall_pct = (p == 0) ? 71 : (p == 1) ? 26 : 0;
         if (p == 2) begin
            // receiver holds off while a long literal keeps coming
            hold_req = 1'b1;
            lit_q.delete();
            lit_q.push_back(CH_DQUOTE);
            for (i = 0; i < PRESSURE_LEN; i++) begin
               do c = 8'($urandom_range(255)); while (c == CH_BACKSLASH);
               lit_q.push_back(c);
            end
            lit_q.push_back(CH_DQUOTE);
            send_lit();
         end
         counted = 0;
         while (counted < PHASE_BYTES) begin
            build_literal();
            send_lit();
            if (!lit_is_noise) counted += lit_q.size();
         end
         if (p == 0) drain();
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
